// ===== rtl/ack_retransmit_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the acknowledgement tracker
// Concurrent checks clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ACK_RETRANSMIT_TRACKER_MACROS_SVH
`define ACK_RETRANSMIT_TRACKER_MACROS_SVH

// The expression holds at every clock edge out of reset.
`define ART_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ART_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/art_pkg.sv =====
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants of the acknowledgement tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package art_pkg;

   localparam int TABLE_DEPTH = 8;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RETRY   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACK     = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_NAK     = 2'd3;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [3:0]  RETRY_RESET   = 4'd3;
   localparam logic [7:0]  ACK_RESET     = 8'd128;
   localparam logic [7:0]  NAK_RESET     = 8'd129;

   localparam logic [1:0] FUNC_SEND = 2'd0;
   localparam logic [1:0] FUNC_RECV = 2'd1;
   localparam logic [1:0] FUNC_POLL = 2'd2;

   typedef enum logic [2:0] {
      KIND_SEND = 3'd0,
      KIND_RECV = 3'd1,
      KIND_RETX = 3'd2,
      KIND_DROP = 3'd3,
      KIND_POLL = 3'd4
   } kind_type;

   typedef struct packed {
      logic [15:0] expiry_ms;
      logic [3:0]  retry_limit;
      logic [7:0]  ack_code;
      logic [7:0]  nak_code;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  command;
      logic [7:0]  seq_num;
      logic [3:0]  retries;
      logic [31:0] sent_time;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } ram_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/art_ifs.sv =====
// ----------------------------------------------------------------------------
// Tracker channels
// Request, response and register write channels with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface art_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  cmd_code;
   logic [7:0]  rx_seq;
   logic [31:0] now_ms;

   modport source (output valid, func, cmd_code, rx_seq, now_ms, input ready);
   modport sink   (input valid, func, cmd_code, rx_seq, now_ms, output ready);
endinterface

interface art_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] seq_out;
   logic [7:0] cmd_out;
   logic [3:0] retry_out;
   logic       flag;
   logic [3:0] pending_now;
   logic       last;

   modport source (output valid, kind, seq_out, cmd_out, retry_out, flag, pending_now,
                   last, input ready);
   modport sink   (input valid, kind, seq_out, cmd_out, retry_out, flag, pending_now,
                   last, output ready);
endinterface

interface art_csr_if;
   logic                             valid;
   logic                             ready;
   logic [art_pkg::CSR_ADDR_W-1:0]   addr;
   logic [art_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/art_ram.sv =====
// ----------------------------------------------------------------------------
// art_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module art_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic                                       re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/art_csr.sv =====
// ----------------------------------------------------------------------------
// art_csr
// Configuration registers: timeout, retry limit, ack and nak codes.
// ----------------------------------------------------------------------------
`default_nettype none

module art_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   art_csr_if.sink          csr_chan,
   output art_pkg::cfg_type cfg
);
   import art_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expiry_ms   <= TIMEOUT_RESET;
         cfg_ff.retry_limit <= RETRY_RESET;
         cfg_ff.ack_code    <= ACK_RESET;
         cfg_ff.nak_code    <= NAK_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.addr)
            CSR_TIMEOUT: cfg_ff.expiry_ms   <= csr_chan.data;
            CSR_RETRY:   cfg_ff.retry_limit <= csr_chan.data[3:0];
            CSR_ACK:     cfg_ff.ack_code    <= csr_chan.data[7:0];
            CSR_NAK:     cfg_ff.nak_code    <= csr_chan.data[7:0];
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/art_ctrl.sv =====
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer that reads, updates and compacts the pending table in the RAM.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ack_retransmit_tracker_macros.svh"

module art_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire art_pkg::cfg_type            cfg,
   art_req_if.sink                          req_chan,
   art_rsp_if.source                        rsp_chan,
   output art_pkg::ram_cmd_type             ram_cmd,
   input  wire logic [art_pkg::ENTRY_W-1:0] ram_rdata
);
   import art_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_COUNT,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       next_seq_ff, next_seq_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] keep_ff, keep_in;
   logic [CNT_W-1:0] surv_ff, surv_in;
   logic             matched_ff, matched_in;
   logic [7:0]       rseq_ff, rseq_in;
   logic [31:0]      now_ff, now_in;
   kind_type         done_kind_ff, done_kind_in;

   logic             rsp_valid_ff, rsp_valid_in;
   kind_type         rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_seq_ff, rsp_seq_in;
   logic [7:0]       rsp_cmd_ff, rsp_cmd_in;
   logic [3:0]       rsp_retry_ff, rsp_retry_in;
   logic             rsp_flag_ff, rsp_flag_in;
   logic [3:0]       rsp_pending_ff, rsp_pending_in;
   logic             rsp_last_ff, rsp_last_in;

   entry_type        rd_entry;
   logic [31:0]      elapsed;
   logic             expired;
   logic             drop;
   logic             out_free;
   logic             req_accept;
   logic [CNT_W-1:0] next_idx;
   logic [CNT_W-1:0] prev_idx;
   logic [CNT_W-1:0] keep_next;
   logic             more;
   logic             stored;
   logic             walk_end;
   logic             emit;
   kind_type         res_kind;
   logic [7:0]       res_seq;
   logic [7:0]       res_cmd;
   logic [3:0]       res_retry;
   logic             res_flag;
   logic [CNT_W-1:0] res_pending;
   logic             res_last;

   assign rd_entry   = entry_type'(ram_rdata);
   assign elapsed    = now_ff - rd_entry.sent_time;
   assign expired    = elapsed > {16'd0, cfg.expiry_ms};
   assign drop       = expired && (rd_entry.retries >= cfg.retry_limit);
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept = req_chan.valid && req_chan.ready;
   assign next_idx   = idx_ff + 1'b1;
   assign prev_idx   = idx_ff - 1'b1;
   assign more       = next_idx < count_ff;
   assign stored     = count_ff < DEPTH_CNT;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      next_seq_in  = next_seq_ff;
      idx_in       = idx_ff;
      keep_in      = keep_ff;
      surv_in      = surv_ff;
      matched_in   = matched_ff;
      rseq_in      = rseq_ff;
      now_in       = now_ff;
      done_kind_in = done_kind_ff;
      keep_next    = keep_ff;
      walk_end     = 1'b0;
      ram_cmd      = '0;
      emit         = 1'b0;
      res_kind     = KIND_POLL;
      res_seq      = 8'd0;
      res_cmd      = 8'd0;
      res_retry    = 4'd0;
      res_flag     = 1'b0;
      res_pending  = count_ff;
      res_last     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rseq_in = req_chan.rx_seq;
               now_in  = req_chan.now_ms;
               if (req_chan.func == FUNC_SEND) begin
                  next_seq_in = next_seq_ff + 8'd1;
                  if (stored) begin
                     ram_cmd.we                = 1'b1;
                     ram_cmd.waddr             = count_ff[IDX_W-1:0];
                     ram_cmd.wdata.command     = req_chan.cmd_code;
                     ram_cmd.wdata.seq_num     = next_seq_ff;
                     ram_cmd.wdata.retries     = 4'd0;
                     ram_cmd.wdata.sent_time   = req_chan.now_ms;
                     count_in                  = count_ff + 1'b1;
                  end
                  emit        = 1'b1;
                  res_kind    = KIND_SEND;
                  res_seq     = next_seq_ff;
                  res_flag    = stored;
                  res_pending = count_in;
                  res_last    = 1'b1;
               end else if (req_chan.func == FUNC_RECV) begin
                  if ((req_chan.cmd_code == cfg.ack_code || req_chan.cmd_code == cfg.nak_code)
                      && count_ff != '0) begin
                     ram_cmd.re   = 1'b1;
                     ram_cmd.raddr = '0;
                     idx_in       = '0;
                     matched_in   = 1'b0;
                     done_kind_in = KIND_RECV;
                     state_in     = ST_SEARCH;
                  end else begin
                     emit     = 1'b1;
                     res_kind = KIND_RECV;
                     res_seq  = req_chan.rx_seq;
                     res_last = 1'b1;
                  end
               end else if (req_chan.func == FUNC_POLL) begin
                  if (count_ff != '0) begin
                     ram_cmd.re    = 1'b1;
                     ram_cmd.raddr = '0;
                     idx_in        = '0;
                     surv_in       = '0;
                     done_kind_in  = KIND_POLL;
                     state_in      = ST_COUNT;
                  end else begin
                     emit     = 1'b1;
                     res_kind = KIND_POLL;
                     res_last = 1'b1;
                  end
               end
            end
         end

         ST_SEARCH: begin
            if (rd_entry.seq_num == rseq_ff) begin
               matched_in = 1'b1;
               if (more) begin
                  ram_cmd.re    = 1'b1;
                  ram_cmd.raddr = next_idx[IDX_W-1:0];
                  idx_in        = next_idx;
                  state_in      = ST_SHIFT;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = ST_DONE;
               end
            end else if (more) begin
               ram_cmd.re    = 1'b1;
               ram_cmd.raddr = next_idx[IDX_W-1:0];
               idx_in        = next_idx;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_SHIFT: begin
            ram_cmd.we    = 1'b1;
            ram_cmd.waddr = prev_idx[IDX_W-1:0];
            ram_cmd.wdata = rd_entry;
            if (more) begin
               ram_cmd.re    = 1'b1;
               ram_cmd.raddr = next_idx[IDX_W-1:0];
               idx_in        = next_idx;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = ST_DONE;
            end
         end

         ST_COUNT: begin
            if (!drop) begin
               surv_in = surv_ff + 1'b1;
            end
            ram_cmd.re = 1'b1;
            if (more) begin
               ram_cmd.raddr = next_idx[IDX_W-1:0];
               idx_in        = next_idx;
            end else begin
               ram_cmd.raddr = '0;
               idx_in        = '0;
               keep_in       = '0;
               state_in      = ST_WALK;
            end
         end

         ST_WALK: begin
            if (!expired || out_free) begin
               if (expired && !drop) begin
                  ram_cmd.we                = 1'b1;
                  ram_cmd.waddr             = keep_ff[IDX_W-1:0];
                  ram_cmd.wdata.command     = rd_entry.command;
                  ram_cmd.wdata.seq_num     = rd_entry.seq_num;
                  ram_cmd.wdata.retries     = rd_entry.retries + 4'd1;
                  ram_cmd.wdata.sent_time   = now_ff;
                  keep_next                 = keep_ff + 1'b1;
                  emit                      = 1'b1;
                  res_kind                  = KIND_RETX;
                  res_seq                   = rd_entry.seq_num;
                  res_cmd                   = rd_entry.command;
                  res_retry                 = rd_entry.retries + 4'd1;
                  res_pending               = surv_ff;
               end else if (expired) begin
                  emit        = 1'b1;
                  res_kind    = KIND_DROP;
                  res_seq     = rd_entry.seq_num;
                  res_cmd     = rd_entry.command;
                  res_retry   = rd_entry.retries;
                  res_pending = surv_ff;
               end else begin
                  ram_cmd.we    = 1'b1;
                  ram_cmd.waddr = keep_ff[IDX_W-1:0];
                  ram_cmd.wdata = rd_entry;
                  keep_next     = keep_ff + 1'b1;
               end
               keep_in = keep_next;
               if (more) begin
                  ram_cmd.re    = 1'b1;
                  ram_cmd.raddr = next_idx[IDX_W-1:0];
                  idx_in        = next_idx;
               end else begin
                  walk_end = 1'b1;
                  count_in = keep_next;
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               res_kind = done_kind_ff;
               if (done_kind_ff == KIND_RECV) begin
                  res_seq  = rseq_ff;
                  res_flag = matched_ff;
               end
               res_last = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_seq_in     = rsp_seq_ff;
      rsp_cmd_in     = rsp_cmd_ff;
      rsp_retry_in   = rsp_retry_ff;
      rsp_flag_in    = rsp_flag_ff;
      rsp_pending_in = rsp_pending_ff;
      rsp_last_in    = rsp_last_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = res_kind;
         rsp_seq_in     = res_seq;
         rsp_cmd_in     = res_cmd;
         rsp_retry_in   = res_retry;
         rsp_flag_in    = res_flag;
         rsp_pending_in = 4'(res_pending);
         rsp_last_in    = res_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         next_seq_ff  <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_seq_ff  <= next_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      keep_ff        <= keep_in;
      surv_ff        <= surv_in;
      matched_ff     <= matched_in;
      rseq_ff        <= rseq_in;
      now_ff         <= now_in;
      done_kind_ff   <= done_kind_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_seq_ff     <= rsp_seq_in;
      rsp_cmd_ff     <= rsp_cmd_in;
      rsp_retry_ff   <= rsp_retry_in;
      rsp_flag_ff    <= rsp_flag_in;
      rsp_pending_ff <= rsp_pending_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE) && out_free;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = rsp_kind_ff;
   assign rsp_chan.seq_out     = rsp_seq_ff;
   assign rsp_chan.cmd_out     = rsp_cmd_ff;
   assign rsp_chan.retry_out   = rsp_retry_ff;
   assign rsp_chan.flag        = rsp_flag_ff;
   assign rsp_chan.pending_now = rsp_pending_ff;
   assign rsp_chan.last        = rsp_last_ff;

   `ART_ASSERT_ALWAYS(a_count_range, count_ff <= DEPTH_CNT, "Pending count exceeds the table.")
   `ART_ASSERT_ALWAYS(a_keep_behind, state_ff != ST_WALK || keep_ff <= idx_ff, "Compaction overtook the read.")
   `ART_ASSERT_ALWAYS(a_walk_survivors, !walk_end || keep_next == surv_ff, "Poll kept a different number of entries than counted.")
   `ART_ASSERT_NEXT(a_last_to_idle, emit && res_last, state_ff == ST_IDLE, "Final response did not end the request.")
   `ART_ASSERT_ALWAYS(a_emit_free, !emit || out_free, "Response register overwritten while held.")

endmodule

`default_nettype wire

// ===== rtl/ack_retransmit_tracker.sv =====
// ----------------------------------------------------------------------------
// ack_retransmit_tracker
// Ordered table of commands awaiting acknowledgement, with retransmission.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Contents
//   req_chan   in         func, cmd_code, rx_seq, now_ms
//   rsp_chan   out        kind, seq_out, cmd_out, retry_out, flag, pending_now, last
//   csr_chan   in         addr (0 timeout, 1 retry limit, 2 ack, 3 nak), data
//
// A send, a poll of an empty table, and a frame that is not an ack or nak or that
// finds the table empty are answered from idle. An ack or nak frame reads every
// pending entry, matched or not; a poll reads the table twice, to count and then
// to walk it, since the RAM has a single read port. A response held by a stalled
// sink blocks new requests and holds a walk at its next response until it is taken.
// Reset clears the count, the sequence number and the response valid, returns to
// idle and loads the default configuration; the table RAM is not cleared, since
// only entries below the count are ever read.
//
`default_nettype none

module ack_retransmit_tracker (
   input  wire logic clock,
   input  wire logic reset,
   art_req_if.sink   req_chan,
   art_rsp_if.source rsp_chan,
   art_csr_if.sink   csr_chan
);
   import art_pkg::*;

   cfg_type             cfg;
   ram_cmd_type         ram_cmd;
   logic [ENTRY_W-1:0]  ram_rdata;

   art_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   art_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .ram_cmd   (ram_cmd),
      .ram_rdata (ram_rdata)
   );

   art_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_cmd.we),
      .waddr (ram_cmd.waddr),
      .wdata (ram_cmd.wdata),
      .re    (ram_cmd.re),
      .raddr (ram_cmd.raddr),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire
